>>> rtl/ujts_pkg.sv
`timescale 1ns / 1ps
package ujts_pkg;
    localparam int NUM_JOBS  = 8;
    localparam int NUM_LAMPS = 5;
    localparam int TIME_BITS = 32;
    localparam int JOB_W     = 3;
    localparam int PCT_W     = 7;

    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_PAUSE = 3'd3;
    localparam logic [2:0] ACT_COUNT = 3'd4;
    localparam logic [2:0] ACT_QUERY = 3'd5;

    localparam logic       REG_ENABLE  = 1'b0;
    localparam logic       REG_LIMITED = 1'b1;

    localparam logic [7:0] ENABLE_RST  = 8'd213;
    localparam logic [7:0] LIMITED_RST = 8'd16;
    localparam int         TRAY_JOB    = 4;
    localparam logic [7:0] TRAY_STARTS = 8'd6;
    localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic [2:0]           action;
        logic [JOB_W-1:0]     job;
        time_t                off_time;
        time_t                on_time;
        logic                 pause_flag;
        logic [7:0]           limit_count;
    } in_word_t;

    typedef struct packed {
        logic [NUM_LAMPS-1:0] lamp_mask;
        logic                 job_active;
        logic                 job_paused;
        logic [PCT_W-1:0]     percent_done;
        logic                 start_accepted;
    } out_word_t;

    // Divider control between the sequencer and the serial divider.
    typedef struct packed {
        logic  start;
        time_t done_ticks;
        time_t total;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [PCT_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [2:0] lamp_of(input int unsigned j);
        logic [2:0] l;
        case (j)
            0, 1:    l = 3'd0;
            2, 3:    l = 3'd1;
            4, 5:    l = 3'd2;
            6:       l = 3'd3;
            7:       l = 3'd4;
            default: l = 3'(NUM_LAMPS - 1);
        endcase
        if (int'(l) >= NUM_LAMPS) l = 3'(NUM_LAMPS - 1);
        return l;
    endfunction
endpackage

>>> rtl/ujts_if.sv
`timescale 1ns / 1ps
interface ujts_in_if import ujts_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ujts_out_if import ujts_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ujts_cfg_if ();
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/uv_job_timer_scheduler_top.sv
`timescale 1ns / 1ps
// Lamp job timer table for eight jobs on five lamps. Each input word is one
// action (tick, start, stop, set pause, load count, query) and gives exactly
// one result word with the lamp mask from the last tick and the status of the
// addressed job after the action. Jobs are held in registers and are worked
// one at a time by a small sequencer: a tick walks all jobs, one job per
// cycle, through a single shared decrement unit, and every action then runs
// the percent-done division in a serial divider that yields one quotient bit
// per cycle. The input is not ready while an item is worked. The result sits
// in an output register, and the next word is taken once the result has been
// delivered. Configuration writes are always accepted.
module uv_job_timer_scheduler_top import ujts_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    ujts_in_if.sink      in_ch,
    ujts_out_if.source   out_ch,
    ujts_cfg_if.sink     cfg_ch
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TICK = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    time_t                delay_reg [NUM_JOBS];
    time_t                left_reg  [NUM_JOBS];
    time_t                total_reg [NUM_JOBS];
    logic [NUM_JOBS-1:0]  paused_reg;
    logic [7:0]           starts_reg [NUM_JOBS];
    logic [NUM_LAMPS-1:0] lamps_reg, mask_reg;
    logic [7:0]           enable_reg, limited_reg;
    logic [2:0]           state_reg;
    logic [JOB_W-1:0]     idx_reg;
    in_word_t             item_reg;
    logic                 acc_reg;
    out_word_t            out_reg;
    div_req_t             dreq;
    div_rsp_t             drsp;

    logic [JOB_W-1:0] j;
    logic             in_fire;
    time_t            dec_in, dec_out;
    logic             tick_active;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data = out_reg;
    assign j = item_reg.job;

    // Shared saturating decrement used by the tick walk.
    assign tick_active = (delay_reg[idx_reg] == '0) && (left_reg[idx_reg] != '0)
                         && !paused_reg[idx_reg];
    assign dec_in  = tick_active ? left_reg[idx_reg] : delay_reg[idx_reg];
    assign dec_out = (dec_in == '0) ? '0 : dec_in - time_t'(1);

    always_comb
    begin
        dreq.start = (state_reg == S_DIV);
        dreq.total = total_reg[j];
        dreq.done_ticks = (left_reg[j] > total_reg[j]) ? '0 : total_reg[j] - left_reg[j];
    end

    ujts_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            enable_reg  <= ENABLE_RST;
            limited_reg <= LIMITED_RST;
            lamps_reg   <= '0;
            paused_reg  <= '0;
            idx_reg     <= '0;
            mask_reg    <= '0;
            acc_reg     <= 1'b0;
            item_reg    <= '0;
            for (int k = 0; k < NUM_JOBS; k++)
            begin
                delay_reg[k]  <= '0;
                left_reg[k]   <= '0;
                total_reg[k]  <= '0;
                starts_reg[k] <= (k == TRAY_JOB) ? TRAY_STARTS : 8'd0;
            end
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                if (cfg_ch.index == REG_ENABLE) enable_reg <= cfg_ch.wdata;
                else limited_reg <= cfg_ch.wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        item_reg <= in_ch.data;
                        idx_reg  <= '0;
                        mask_reg <= '0;
                        acc_reg  <= 1'b0;
                        state_reg <= (in_ch.data.action == ACT_TICK) ? S_TICK : S_DIV;
                        case (in_ch.data.action)
                            ACT_START:
                            begin
                                if (enable_reg[in_ch.data.job] &&
                                    !(limited_reg[in_ch.data.job] &&
                                      starts_reg[in_ch.data.job] == 8'd0))
                                begin
                                    if (starts_reg[in_ch.data.job] != 8'd0)
                                        starts_reg[in_ch.data.job] <=
                                            starts_reg[in_ch.data.job] - 8'd1;
                                    delay_reg[in_ch.data.job] <= in_ch.data.off_time;
                                    left_reg[in_ch.data.job]  <= in_ch.data.on_time;
                                    total_reg[in_ch.data.job] <= in_ch.data.on_time;
                                    acc_reg <= 1'b1;
                                end
                            end
                            ACT_STOP:
                            begin
                                delay_reg[in_ch.data.job] <= '0;
                                left_reg[in_ch.data.job]  <= '0;
                                total_reg[in_ch.data.job] <= '0;
                            end
                            ACT_PAUSE: paused_reg[in_ch.data.job] <= in_ch.data.pause_flag;
                            ACT_COUNT: starts_reg[in_ch.data.job] <= in_ch.data.limit_count;
                            default: ;
                        endcase
                    end
                end
                S_TICK:
                begin
                    if (tick_active)
                    begin
                        left_reg[idx_reg] <= dec_out;
                        mask_reg[lamp_of(32'(idx_reg))] <= 1'b1;
                    end
                    else
                        delay_reg[idx_reg] <= dec_out;
                    if (idx_reg == JOB_W'(NUM_JOBS - 1))
                    begin
                        lamps_reg <= mask_reg |
                            (tick_active ? (NUM_LAMPS'(1) << lamp_of(32'(idx_reg)))
                                         : '0);
                        state_reg <= S_DIV;
                    end
                    else
                        idx_reg <= idx_reg + JOB_W'(1);
                end
                S_DIV: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (drsp.done) state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WAIT && drsp.done)
        begin
            out_reg.lamp_mask      <= lamps_reg;
            out_reg.job_active     <= (delay_reg[j] == '0) && (left_reg[j] != '0);
            out_reg.job_paused     <= paused_reg[j];
            out_reg.percent_done   <= (total_reg[j] == '0) ? '0 : drsp.quotient;
            out_reg.start_accepted <= acc_reg;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != S_IDLE) else $error("accepted twice");
    a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(drsp.done)) else $error("result without divide");
    a_acc_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_reg.start_accepted |-> item_reg.action == ACT_START)
        else $error("accept flag on non-start");
    a_no_div_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !drsp.busy) else $error("divider busy at idle");
endmodule

>>> rtl/ujts_div.sv
`timescale 1ns / 1ps
module ujts_div import ujts_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    // Restoring division of done*100 by total, one quotient bit a cycle.
    // done <= total, so the quotient fits in PCT_W bits.
    localparam int NUM_W = TIME_BITS + PCT_W;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [TIME_BITS:0]   rem_reg, rem_next;
    time_t                den_reg, den_next;
    logic [PCT_W-1:0]     q_reg, q_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TIME_BITS+1:0] trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[NUM_W-1]} - {2'b00, den_reg};
        if (req.start)
        begin
            // The scale by 100 is built from shifts: 100 = 64 + 32 + 4.
            num_next  = (NUM_W'(req.done_ticks) << 6) + (NUM_W'(req.done_ticks) << 5)
                        + (NUM_W'(req.done_ticks) << 2);
            den_next  = req.total;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 6'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (!trial[TIME_BITS+1])
            begin
                rem_next = trial[TIME_BITS:0];
                q_next   = {q_reg[PCT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[TIME_BITS-1:0], num_reg[NUM_W-1]};
                q_next   = {q_reg[PCT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg)) else $error("div done without busy");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start) else $error("div restarted while busy");
    // A zero divisor yields all ones here; the sequencer replaces it by zero.
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done && den_reg != '0 |-> q_reg <= FULL_PERCENT)
        else $error("percent above 100");
endmodule
